[rtl/psc_pkg.sv]
// psc_pkg: service, confidence and score codes plus byte and signature helpers
// for the packet service classifier. No dependencies.
package psc_pkg;

  localparam int HEAD_BYTES = 8;

  localparam logic [3:0] SVC_UNKNOWN = 4'd0;
  localparam logic [3:0] SVC_HTTP    = 4'd1;
  localparam logic [3:0] SVC_DNS     = 4'd2;
  localparam logic [3:0] SVC_TLS     = 4'd3;
  localparam logic [3:0] SVC_SSH     = 4'd4;
  localparam logic [3:0] SVC_FTP     = 4'd5;
  localparam logic [3:0] SVC_SMTP    = 4'd6;
  localparam logic [3:0] SVC_SMB     = 4'd7;
  localparam logic [3:0] SVC_ICMP    = 4'd8;
  localparam logic [3:0] SVC_GEN_TCP = 4'd9;
  localparam logic [3:0] SVC_GEN_UDP = 4'd10;

  localparam logic [1:0] CONF_SUSPECTED  = 2'd0;
  localparam logic [1:0] CONF_IDENTIFIED = 2'd1;
  localparam logic [1:0] CONF_CONFLICTED = 2'd2;

  localparam logic [2:0] KIND_TCP    = 3'd0;
  localparam logic [2:0] KIND_UDP    = 3'd1;
  localparam logic [2:0] KIND_ICMP   = 3'd2;
  localparam logic [2:0] KIND_ICMPV6 = 3'd3;

  localparam logic [6:0] SCORE_NONE     = 7'd0;
  localparam logic [6:0] SCORE_FALLBACK = 7'd10;
  localparam logic [6:0] SCORE_HINT     = 7'd25;
  localparam logic [6:0] SCORE_DNS      = 7'd55;
  localparam logic [6:0] SCORE_FTP      = 7'd60;
  localparam logic [6:0] SCORE_SMTP     = 7'd70;
  localparam logic [6:0] SCORE_STRONG   = 7'd80;
  localparam logic [6:0] SCORE_ICMP     = 7'd100;
  localparam logic [6:0] SCORE_SURE     = 7'd70;

  localparam logic [15:0] DNS_HDR_LEN = 16'd12;
  localparam logic [7:0]  TLS_HANDSHAKE = 8'h16;
  localparam logic [7:0]  TLS_MAJOR     = 8'h03;
  localparam logic [7:0]  TLS_MINOR_MAX = 8'h04;

  typedef struct packed {
    logic [3:0] svc;
    logic [6:0] score;
  } evidence_t;

  function automatic logic [7:0] head_byte(input logic [63:0] head, input logic [2:0] idx);
    logic [7:0] b;
    if (int'(idx) >= HEAD_BYTES) begin
      b = 8'h00;
    end else begin
      b = head[8*idx +: 8];
    end
    return b;
  endfunction

  // sig holds the string with its first character in the highest used byte
  function automatic logic sig_hit(input logic [63:0] head, input logic [15:0] len,
                                   input logic [55:0] sig, input logic [2:0] n);
    logic hit;
    hit = (len >= 16'(n));
    for (int i = 0; i < 7; i++) begin
      if (i < int'(n)) begin
        if (head_byte(head, 3'(i)) != sig[8*(int'(n)-1-i) +: 8]) begin
          hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

endpackage

[rtl/packet_service_classifier_top.sv]
// packet_service_classifier_top: classifies one packet summary per cycle while
// the result channel is not stalled. Depends on psc_pkg.
//
// Usage:
//   Input channel in_*: transport kind, destination port, payload length and
//   the first eight payload bytes; a request is taken when in_valid and
//   in_ready are both high.
//   Result channel out_*: service code, confidence level and best score, one
//   result per request, in order.
//   Path: a taken request is held in the input register; its result is then
//   captured in the result register, which drives out_valid.
//   Throughput: one request per cycle while out_ready stays high; the match
//   and select logic between the two registers is combinational.
//   Reset: synchronous active-low rst_n empties both stages, out_valid low.
//   Receiver stall: the result register holds; the input stage still takes
//   a request if it is empty, then in_ready drops until out_ready returns.
module packet_service_classifier_top
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_transport_kind,
  input  logic [15:0] in_dest_port,
  input  logic [15:0] in_payload_length,
  input  logic [63:0] in_head_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_service_code,
  output logic [1:0]  out_confidence_level,
  output logic [6:0]  out_best_score
);

  logic        s1_vld_r, s1_vld_nxt;
  logic [2:0]  kind_r;
  logic [15:0] port_r;
  logic [15:0] len_r;
  logic [63:0] head_r;

  logic        out_vld_r, out_vld_nxt;
  logic [3:0]  svc_r, svc_nxt;
  logic [1:0]  conf_r, conf_nxt;
  logic [6:0]  score_r, score_nxt;

  logic        adv_out, adv_in;
  evidence_t   hint, sig;

  assign adv_out  = !out_vld_r || out_ready;
  assign adv_in   = !s1_vld_r || adv_out;
  assign in_ready = adv_in;

  assign s1_vld_nxt  = adv_in ? in_valid : s1_vld_r;
  assign out_vld_nxt = adv_out ? s1_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) begin
      kind_r <= in_transport_kind;
      port_r <= in_dest_port;
      len_r  <= in_payload_length;
      head_r <= in_head_bytes;
    end
    if (adv_out) begin
      svc_r   <= svc_nxt;
      conf_r  <= conf_nxt;
      score_r <= score_nxt;
    end
  end

  // evidence gathering
  always_comb begin
    hint = '{svc: SVC_UNKNOWN, score: SCORE_NONE};
    sig  = '{svc: SVC_UNKNOWN, score: SCORE_NONE};
    if (kind_r == KIND_TCP) begin
      priority if (port_r == 16'd80 || port_r == 16'd8080 || port_r == 16'd8000) begin
        hint = '{svc: SVC_HTTP, score: SCORE_HINT};
      end else if (port_r == 16'd443 || port_r == 16'd8443) begin
        hint = '{svc: SVC_TLS, score: SCORE_HINT};
      end else if (port_r == 16'd22) begin
        hint = '{svc: SVC_SSH, score: SCORE_HINT};
      end else if (port_r == 16'd21) begin
        hint = '{svc: SVC_FTP, score: SCORE_HINT};
      end else if (port_r == 16'd25 || port_r == 16'd587 || port_r == 16'd465) begin
        hint = '{svc: SVC_SMTP, score: SCORE_HINT};
      end else if (port_r == 16'd445 || port_r == 16'd139) begin
        hint = '{svc: SVC_SMB, score: SCORE_HINT};
      end else begin
        hint = '{svc: SVC_UNKNOWN, score: SCORE_NONE};
      end

      priority if (sig_hit(head_r, len_r, 56'("GET "), 3'd4) ||
                   sig_hit(head_r, len_r, 56'("POST "), 3'd5) ||
                   sig_hit(head_r, len_r, 56'("PUT "), 3'd4) ||
                   sig_hit(head_r, len_r, 56'("HEAD "), 3'd5) ||
                   sig_hit(head_r, len_r, 56'("HTTP/1."), 3'd7)) begin
        sig = '{svc: SVC_HTTP, score: SCORE_STRONG};
      end else if (len_r >= 16'd3 && head_byte(head_r, 3'd0) == TLS_HANDSHAKE &&
                   head_byte(head_r, 3'd1) == TLS_MAJOR &&
                   head_byte(head_r, 3'd2) <= TLS_MINOR_MAX) begin
        sig = '{svc: SVC_TLS, score: SCORE_STRONG};
      end else if (sig_hit(head_r, len_r, 56'("SSH-"), 3'd4)) begin
        sig = '{svc: SVC_SSH, score: SCORE_STRONG};
      end else if (sig_hit(head_r, len_r, 56'("220 "), 3'd4) ||
                   sig_hit(head_r, len_r, 56'("EHLO "), 3'd5) ||
                   sig_hit(head_r, len_r, 56'("HELO "), 3'd5)) begin
        sig = '{svc: SVC_SMTP, score: SCORE_SMTP};
      end else if (sig_hit(head_r, len_r, 56'("USER "), 3'd5) ||
                   sig_hit(head_r, len_r, 56'("220-"), 3'd4)) begin
        sig = '{svc: SVC_FTP, score: SCORE_FTP};
      end else begin
        sig = '{svc: SVC_UNKNOWN, score: SCORE_NONE};
      end
    end else if (kind_r == KIND_UDP) begin
      if (port_r == 16'd53) begin
        hint = '{svc: SVC_DNS, score: SCORE_HINT};
      end
      if (len_r >= DNS_HDR_LEN) begin
        sig = '{svc: SVC_DNS, score: SCORE_DNS};
      end
    end
  end

  // winner and confidence
  always_comb begin
    priority if (kind_r == KIND_ICMP || kind_r == KIND_ICMPV6) begin
      svc_nxt   = SVC_ICMP;
      conf_nxt  = CONF_IDENTIFIED;
      score_nxt = SCORE_ICMP;
    end else if (hint.score == SCORE_NONE && sig.score == SCORE_NONE) begin
      svc_nxt   = (kind_r == KIND_TCP) ? SVC_GEN_TCP : SVC_GEN_UDP;
      conf_nxt  = CONF_SUSPECTED;
      score_nxt = SCORE_FALLBACK;
    end else begin
      if (sig.score > hint.score) begin
        svc_nxt   = sig.svc;
        score_nxt = sig.score;
      end else begin
        svc_nxt   = hint.svc;
        score_nxt = hint.score;
      end
      priority if (sig.score >= SCORE_SURE && hint.score != SCORE_NONE &&
                   hint.svc != sig.svc) begin
        conf_nxt = CONF_CONFLICTED;
      end else if (score_nxt >= SCORE_SURE) begin
        conf_nxt = CONF_IDENTIFIED;
      end else begin
        conf_nxt = CONF_SUSPECTED;
      end
    end
  end

  assign out_valid            = out_vld_r;
  assign out_service_code     = svc_r;
  assign out_confidence_level = conf_r;
  assign out_best_score       = score_r;

endmodule

[rtl/psc_checker.sv]
// psc_checker: port-level assertions for packet_service_classifier_top,
// attached by the bind below. Depends on psc_pkg.
module psc_checker
  import psc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_service_code,
  input logic [1:0]  out_confidence_level,
  input logic [6:0]  out_best_score
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_service_code) &&
    $stable(out_confidence_level) && $stable(out_best_score))
    else $error("result changed while stalled");

  a_icmp_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_service_code == SVC_ICMP |->
    out_confidence_level == CONF_IDENTIFIED && out_best_score == SCORE_ICMP)
    else $error("icmp result not fixed");

  a_conf_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_confidence_level != CONF_SUSPECTED |-> out_best_score >= SCORE_SURE)
    else $error("strong confidence with weak score");

endmodule

bind packet_service_classifier_top psc_checker u_psc_checker (.*);
